/* rtl/windowed_sender_congestion_control_macros.svh */
// Assertion macros used by the windowed sender datapath.
`ifndef WINDOWED_SENDER_CONGESTION_CONTROL_MACROS_SVH
`define WINDOWED_SENDER_CONGESTION_CONTROL_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define WSCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check that a condition holds at every cycle out of reset
`define WSCC_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

/* rtl/wscc_pkg.sv */
// Types, constants and control structs for the windowed sender.
`default_nettype none

package wscc_pkg;

  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned WIN_W      = 37;
  localparam int unsigned WINI_W     = 21;
  localparam int unsigned FIX_W      = 40;
  localparam int unsigned GAIN_W     = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned TMO_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;

  localparam logic [WIN_W-1:0]  ONE_FIX    = 37'h0_0001_0000;
  localparam logic [WIN_W-1:0]  WIN_RESET  = 37'h0_0080_0000;
  localparam logic [WINI_W-1:0] THR_RESET  = 21'd128;
  localparam logic [FIX_W-1:0]  EST_RESET  = 40'd12800;
  localparam logic [WINI_W-1:0] MAXW_RESET = 21'h10_0000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd4;
  localparam logic [SEQ_W-1:0]  SEQ_RESET  = 32'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SEND = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_TIME = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SENT       = 3'd0,
    KIND_REFUSED    = 3'd1,
    KIND_ACKED      = 3'd2,
    KIND_UNMATCHED  = 3'd3,
    KIND_NO_TIMEOUT = 3'd4,
    KIND_RETX       = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_ACK  = 2'd1,
    SEL_HOLD = 2'd2,
    SEL_RAM  = 2'd3
  } seqsel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_WINDOW   = 2'd0,
    CFG_TIMEOUT_GAIN = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] send;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    latch;
    logic    push;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_idx;
    logic    rd_idx1;
    logic    rd_zero;
    logic    wr_shift;
    logic    wr_rtx;
    logic    found_set;
    logic    dec_count;
    logic    rtt_diff;
    logic    rtt_upd;
    logic    rtt_mul;
    logic    tmo_set;
    logic    win_inc;
    logic    div_start;
    logic    div_step;
    logic    win_div;
    logic    timeout_set;
    logic    emit;
    kind_e   emit_kind;
    seqsel_e emit_sel;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic can_send;
    logic idx_at_count;
    logic idx1_at_count;
    logic seq_match;
    logic count_zero;
    logic expired;
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/windowed_sender_congestion_control.sv */
// Top level: windowed sender with congestion window and adaptive retransmit timeout.
// One item at a time: a send, refusal or unknown request, a time check with its retransmits,
// an ack with its list scan, shift and RTT update, plus the congestion-avoidance divide
// (one quotient bit per cycle), or an unmatched ack after its list scan. A result that
// waits on the output holds the controller until it is taken. Reset clears all control
// state at once; the in-flight RAM needs no clearing pass.
`default_nettype none

module windowed_sender_congestion_control #(
  parameter int unsigned INFLIGHT_DEPTH = wscc_pkg::DEPTH_DEF,
  localparam int unsigned CntW = $clog2(INFLIGHT_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [wscc_pkg::REQ_W-1:0]      req_type_i,
  input  logic [wscc_pkg::SEQ_W-1:0]      ack_number_i,
  input  logic [wscc_pkg::TIME_W-1:0]     now_us_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wscc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wscc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wscc_pkg::KIND_W-1:0]     out_kind_o,
  output logic [wscc_pkg::SEQ_W-1:0]      out_seq_o,
  output logic [wscc_pkg::WINI_W-1:0]     window_now_o,
  output logic [wscc_pkg::TMO_W-1:0]      timeout_now_o,
  output logic [CntW-1:0]                 inflight_now_o,
  output logic                            last_of_run_o
);
  import wscc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  wscc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wscc_dp #(
    .INFLIGHT_DEPTH (INFLIGHT_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .ack_number_i   (ack_number_i),
    .now_us_i       (now_us_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_kind_o     (out_kind_o),
    .out_seq_o      (out_seq_o),
    .window_now_o   (window_now_o),
    .timeout_now_o  (timeout_now_o),
    .inflight_now_o (inflight_now_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

/* rtl/wscc_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module wscc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/wscc_dp.sv */
// Datapath: in-flight list, RTT and window arithmetic, divider, output register.
`default_nettype none
`include "windowed_sender_congestion_control_macros.svh"

module wscc_dp #(
  parameter int unsigned INFLIGHT_DEPTH = wscc_pkg::DEPTH_DEF,
  localparam int unsigned CntW = $clog2(INFLIGHT_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wscc_pkg::cmd_t                      cmd_i,
  output wscc_pkg::sts_t                      sts_o,
  input  logic [wscc_pkg::REQ_W-1:0]          req_type_i,
  input  logic [wscc_pkg::SEQ_W-1:0]          ack_number_i,
  input  logic [wscc_pkg::TIME_W-1:0]         now_us_i,
  input  logic                                cfg_valid_i,
  input  logic [wscc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wscc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [wscc_pkg::KIND_W-1:0]         out_kind_o,
  output logic [wscc_pkg::SEQ_W-1:0]          out_seq_o,
  output logic [wscc_pkg::WINI_W-1:0]         window_now_o,
  output logic [wscc_pkg::TMO_W-1:0]          timeout_now_o,
  output logic [CntW-1:0]                     inflight_now_o,
  output logic                                last_of_run_o
);
  import wscc_pkg::*;

  localparam int unsigned AW = $clog2(INFLIGHT_DEPTH);

  req_e              req_q;
  logic [SEQ_W-1:0]  ack_q, nseq_q, hold_q;
  logic [TIME_W-1:0] now_q;
  logic [CntW-1:0]   count_q, idx_q, idx_p1;
  logic [WIN_W-1:0]  win_q;
  logic [WINI_W-1:0] thr_q, maxw_q;
  logic [GAIN_W-1:0] gain_q;
  logic [FIX_W-1:0]  est_q, dev_q, tmo_q, s_q, diff_q;
  logic [43:0]       prod_q;
  logic [37:0]       rem_q;
  logic [32:0]       quo_q;
  logic [5:0]        dcnt_q;

  logic              out_valid_q, out_last_q;
  kind_e             out_kind_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic [WINI_W-1:0] out_win_q;
  logic [TMO_W-1:0]  out_tmo_q;
  logic [CntW-1:0]   out_cnt_q;

  logic [ENTRY_W-1:0] rd_data, wr_data;
  entry_t             rd_ent, wr_ent;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;

  logic [WINI_W-1:0] wint_raw, wclamp, win_int;
  logic              out_free, can_send;
  logic [TIME_W-1:0] dt, elapsed;
  logic [FIX_W-1:0]  s_next, diff_next, dev_next, est_next, tmo_next;
  logic [42:0]       dev_sum, est_sum;
  logic [43:0]       prod_next;
  logic [44:0]       tmo_sum;
  logic [37:0]       cand1, cand_div, r2;
  logic [WIN_W-1:0]  win_inc_next, win_div_next;
  logic              need_div, dbit, ge;

  assign rd_ent = entry_t'(rd_data);
  assign idx_p1 = idx_q + CntW'(1);

  assign wint_raw = win_q[WIN_W-1:16];
  assign wclamp   = (wint_raw > maxw_q) ? maxw_q : wint_raw;
  assign win_int  = (wclamp == '0) ? WINI_W'(1) : wclamp;

  assign can_send = (32'(count_q) < 32'(win_int)) && (32'(count_q) < 32'(INFLIGHT_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;

  assign dt      = now_q - rd_ent.first;
  assign s_next  = (dt[47:32] != '0) ? {32'hFFFF_FFFF, 8'h00} : {dt[31:0], 8'h00};
  assign elapsed = now_q - rd_ent.send;

  assign diff_next = (s_q >= est_q) ? (s_q - est_q) : (est_q - s_q);
  assign dev_sum   = {2'b00, dev_q, 1'b0} + {3'b000, dev_q} + {3'b000, diff_q};
  assign dev_next  = dev_sum[41:2];
  assign est_sum   = {est_q, 3'b000} - {3'b000, est_q} + {3'b000, s_q};
  assign est_next  = est_sum[42:3];
  assign prod_next = 44'(gain_q) * 44'(dev_q);
  assign tmo_sum   = {5'b00000, est_q} + {1'b0, prod_q};
  assign tmo_next  = (tmo_sum[44:40] != '0) ? '1 : tmo_sum[39:0];

  assign cand1        = {1'b0, win_q} + {1'b0, ONE_FIX};
  assign need_div     = cand1 > {1'b0, thr_q, 16'h0000};
  assign win_inc_next = cand1[37] ? '1 : cand1[36:0];

  assign dbit     = (dcnt_q == 6'd32);
  assign r2       = {rem_q[36:0], dbit};
  assign ge       = r2 >= {1'b0, win_q};
  assign cand_div = {1'b0, win_q} + ((win_q == '0) ? 38'd0 : {5'b00000, quo_q});
  assign win_div_next = cand_div[37] ? '1 : cand_div[36:0];

  always_comb begin
    sts_o.req           = req_q;
    sts_o.can_send      = can_send;
    sts_o.idx_at_count  = (idx_q == count_q);
    sts_o.idx1_at_count = (idx_p1 >= count_q);
    sts_o.seq_match     = (rd_ent.seq == ack_q);
    sts_o.count_zero    = (count_q == '0);
    sts_o.expired       = {elapsed, 8'h00} > {16'h0000, tmo_q};
    sts_o.need_div      = need_div;
    sts_o.div_last      = (dcnt_q == '0);
    sts_o.out_free      = out_free;
  end

  always_comb begin
    wr_ent = rd_ent;
    if (cmd_i.push) begin
      wr_ent.seq   = nseq_q;
      wr_ent.first = now_q;
      wr_ent.send  = now_q;
    end else if (cmd_i.wr_rtx) begin
      wr_ent.send  = now_q;
    end
  end

  assign wr_data   = ENTRY_W'(wr_ent);
  assign ram_we    = cmd_i.push || cmd_i.wr_shift || cmd_i.wr_rtx;
  assign ram_waddr = cmd_i.push ? count_q[AW-1:0] : idx_q[AW-1:0];
  assign ram_re    = cmd_i.rd_idx || cmd_i.rd_idx1 || cmd_i.rd_zero;
  assign ram_raddr = cmd_i.rd_zero ? '0 : (cmd_i.rd_idx1 ? idx_p1[AW-1:0] : idx_q[AW-1:0]);

  wscc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (INFLIGHT_DEPTH)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      nseq_q      <= SEQ_RESET;
      win_q       <= WIN_RESET;
      thr_q       <= THR_RESET;
      est_q       <= EST_RESET;
      dev_q       <= '0;
      tmo_q       <= EST_RESET;
      maxw_q      <= MAXW_RESET;
      gain_q      <= GAIN_RESET;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAX_WINDOW:   maxw_q <= cfg_data_i;
          CFG_TIMEOUT_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.push) begin
        count_q <= count_q + CntW'(1);
        nseq_q  <= nseq_q + SEQ_W'(1);
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_p1;
      end
      if (cmd_i.rtt_upd) begin
        dev_q <= dev_next;
        est_q <= est_next;
      end
      if (cmd_i.tmo_set) begin
        tmo_q <= tmo_next;
      end
      if (cmd_i.win_inc) begin
        win_q <= win_inc_next;
      end else if (cmd_i.win_div) begin
        win_q <= win_div_next;
      end else if (cmd_i.timeout_set) begin
        win_q <= ONE_FIX;
      end
      if (cmd_i.timeout_set) begin
        thr_q <= (wint_raw >> 1) + WINI_W'(1);
      end
      if (cmd_i.div_start) begin
        dcnt_q <= 6'd32;
      end else if (cmd_i.div_step && dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 6'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_e'(req_type_i);
      ack_q <= ack_number_i;
      now_q <= now_us_i;
    end
    if (cmd_i.push) begin
      hold_q <= nseq_q;
    end
    if (cmd_i.found_set) begin
      s_q <= s_next;
    end
    if (cmd_i.rtt_diff) begin
      diff_q <= diff_next;
    end
    if (cmd_i.rtt_mul) begin
      prod_q <= prod_next;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (r2 - {1'b0, win_q}) : r2;
      quo_q <= {quo_q[31:0], ge};
    end
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_last_q <= cmd_i.emit_last;
      out_win_q  <= win_int;
      out_tmo_q  <= tmo_q[FIX_W-1:8];
      out_cnt_q  <= count_q;
      unique case (cmd_i.emit_sel)
        SEL_ZERO: out_seq_q <= '0;
        SEL_ACK:  out_seq_q <= ack_q;
        SEL_HOLD: out_seq_q <= hold_q;
        SEL_RAM:  out_seq_q <= rd_ent.seq;
        default:  out_seq_q <= '0;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_seq_o      = out_seq_q;
  assign window_now_o   = out_win_q;
  assign timeout_now_o  = out_tmo_q;
  assign inflight_now_o = out_cnt_q;
  assign last_of_run_o  = out_last_q;

  `WSCC_ASSERT_ALW(a_count_bound, 32'(count_q) <= 32'(INFLIGHT_DEPTH), "in-flight count over depth")
  `WSCC_ASSERT_IMP(a_push_room, cmd_i.push, can_send, "push without room")
  `WSCC_ASSERT_IMP(a_emit_free, cmd_i.emit, out_free, "item emitted over pending result")
  `WSCC_ASSERT_ALW(a_win_nonzero, win_q != '0, "window register reached zero")

endmodule

`default_nettype wire

/* rtl/wscc_ctrl.sv */
// Controller: sequences send, ack scan, list shift, RTT update, divide and retransmit.
`default_nettype none

module wscc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wscc_pkg::sts_t sts_i,
  output wscc_pkg::cmd_t cmd_o
);
  import wscc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_RTT_DIFF, S_RTT_UPD, S_RTT_MUL, S_RTT_TMO, S_DIV, S_WIN_DIV,
    S_TC_CMP, S_RTX_RD, S_RTX_WR, S_EMIT
  } state_e;

  state_e  state_q, state_d;
  kind_e   kind_q, kind_d;
  seqsel_e sel_q, sel_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.emit_kind = kind_q;
    cmd_o.emit_sel  = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.req)
          REQ_SEND: begin
            if (sts_i.can_send) begin
              cmd_o.push = 1'b1;
              kind_d = KIND_SENT;
              sel_d  = SEL_HOLD;
            end else begin
              kind_d = KIND_REFUSED;
              sel_d  = SEL_ZERO;
            end
            state_d = S_EMIT;
          end
          REQ_ACK: begin
            cmd_o.idx_clr = 1'b1;
            state_d = S_SCAN_RD;
          end
          REQ_TIME: begin
            if (sts_i.count_zero) begin
              kind_d  = KIND_NO_TIMEOUT;
              sel_d   = SEL_ZERO;
              state_d = S_EMIT;
            end else begin
              cmd_o.rd_zero = 1'b1;
              state_d = S_TC_CMP;
            end
          end
          default: begin
            kind_d  = KIND_NO_TIMEOUT;
            sel_d   = SEL_ZERO;
            state_d = S_EMIT;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts_i.idx_at_count) begin
          kind_d  = KIND_UNMATCHED;
          sel_d   = SEL_ACK;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.seq_match) begin
          cmd_o.found_set = 1'b1;
          state_d = S_SHIFT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.idx1_at_count) begin
          state_d = S_RTT_DIFF;
        end else begin
          cmd_o.rd_idx1 = 1'b1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_RTT_DIFF: begin
        cmd_o.dec_count = 1'b1;
        cmd_o.rtt_diff  = 1'b1;
        state_d = S_RTT_UPD;
      end
      S_RTT_UPD: begin
        cmd_o.rtt_upd = 1'b1;
        state_d = S_RTT_MUL;
      end
      S_RTT_MUL: begin
        cmd_o.rtt_mul = 1'b1;
        state_d = S_RTT_TMO;
      end
      S_RTT_TMO: begin
        cmd_o.tmo_set = 1'b1;
        kind_d = KIND_ACKED;
        sel_d  = SEL_ACK;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.win_inc = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WIN_DIV;
        end
      end
      S_WIN_DIV: begin
        cmd_o.win_div = 1'b1;
        state_d = S_EMIT;
      end
      S_TC_CMP: begin
        if (sts_i.expired) begin
          cmd_o.timeout_set = 1'b1;
          cmd_o.idx_clr     = 1'b1;
          state_d = S_RTX_RD;
        end else begin
          kind_d  = KIND_NO_TIMEOUT;
          sel_d   = SEL_ZERO;
          state_d = S_EMIT;
        end
      end
      S_RTX_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_RTX_WR;
      end
      S_RTX_WR: begin
        if (sts_i.out_free) begin
          cmd_o.wr_rtx    = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_RETX;
          cmd_o.emit_sel  = SEL_RAM;
          cmd_o.emit_last = sts_i.idx1_at_count;
          state_d = sts_i.idx1_at_count ? S_IDLE : S_RTX_RD;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_NO_TIMEOUT;
      sel_q   <= SEL_ZERO;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire
